// ----- sv/hss_pkg.sv -----
// ----------------------------------------------------------------------------
// hss_pkg
// Shared types and constants for the Horspool substring search block.
// ----------------------------------------------------------------------------
package hss_pkg;

   localparam int MAX_PATTERN_DEFAULT = 64;
   localparam int MAX_LINE_DEFAULT    = 2048;
   localparam int QUEUE_DEPTH         = 4;
   localparam int POS_W               = 11;
   localparam int STATUS_W            = 2;

   typedef enum logic [STATUS_W-1:0] {
      ST_NO_MATCH  = 2'd0,
      ST_MATCH     = 2'd1,
      ST_PAT_LONG  = 2'd2,
      ST_LINE_LONG = 2'd3
   } status_type;

   typedef struct packed {
      logic       is_text;
      logic [7:0] data;
      logic       last;
   } item_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FILL,
      S_WRD,
      S_WWR,
      S_CHK,
      S_CRD,
      S_CCMP,
      S_TRD,
      S_TBL,
      S_SHF,
      S_OUT
   } state_type;

endpackage

// ----- sv/hss_ram.sv -----
// ----------------------------------------------------------------------------
// hss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/hss_front.sv -----
// ----------------------------------------------------------------------------
// hss_front
// Accepts input transactions, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module hss_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              in_op,
   input  logic [7:0]        in_data,
   input  logic              in_last,
   output logic              out_valid,
   input  logic              out_pop,
   output hss_pkg::item_type out_item
);

   localparam int QA_W = $clog2(hss_pkg::QUEUE_DEPTH);
   localparam int QC_W = $clog2(hss_pkg::QUEUE_DEPTH + 1);

   hss_pkg::item_type q_ff [hss_pkg::QUEUE_DEPTH];
   logic [QA_W-1:0]   wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QC_W-1:0]   cnt_ff, cnt_in;
   logic              push;
   logic              pop;
   hss_pkg::item_type new_item;

   assign in_ready  = (cnt_ff != QC_W'(hss_pkg::QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign push      = in_valid & in_ready;
   assign pop       = out_pop & out_valid;
   assign out_item  = q_ff[rptr_ff];

   always_comb begin
      new_item.is_text = in_op;
      new_item.data    = in_data;
      new_item.last    = in_last;
      wptr_in = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff + QC_W'(push) - QC_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= new_item;
      end
   end

endmodule

// ----- sv/hss_engine.sv -----
// ----------------------------------------------------------------------------
// hss_engine
// Stores pattern and line bytes, builds the shift table and runs the search.
// ----------------------------------------------------------------------------
module hss_engine #(
   parameter int MAX_PATTERN = hss_pkg::MAX_PATTERN_DEFAULT,
   parameter int MAX_LINE    = hss_pkg::MAX_LINE_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   output logic                          item_pop,
   input  hss_pkg::item_type             item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hss_pkg::STATUS_W-1:0]  rsp_status,
   output logic [hss_pkg::POS_W-1:0]     rsp_pos
);

   localparam int PCNT_W = $clog2(MAX_PATTERN + 1);
   localparam int LCNT_W = $clog2(MAX_LINE + 1);
   localparam int PA_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LA_W   = $clog2(MAX_LINE);
   localparam int END_W  = ((LCNT_W > PCNT_W) ? LCNT_W : PCNT_W) + 1;

   hss_pkg::state_type state_ff, state_in;

   logic [PCNT_W-1:0] plen_ff, plen_in;
   logic              pfresh_ff, pfresh_in;
   logic              pov_ff, pov_in;
   logic [LCNT_W-1:0] tlen_ff, tlen_in;
   logic              tov_ff, tov_in;
   logic [7:0]        idx_ff, idx_in;
   logic [PCNT_W-1:0] k_ff, k_in;
   logic [PCNT_W-1:0] j_ff, j_in;
   logic [END_W-1:0]  end_ff, end_in;
   logic [hss_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [hss_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic              rvalid_ff, rvalid_in;
   logic [hss_pkg::STATUS_W-1:0] rstatus_ff, rstatus_in;
   logic [hss_pkg::POS_W-1:0]    rpos_ff, rpos_in;

   logic              p_we, t_we, s_we;
   logic [PA_W-1:0]   p_waddr, p_raddr;
   logic [LA_W-1:0]   t_waddr, t_raddr;
   logic [7:0]        s_waddr, s_raddr;
   logic [7:0]        p_wdata, t_wdata;
   logic [PCNT_W-1:0] s_wdata;
   logic [7:0]        p_rdata, t_rdata;
   logic [PCNT_W-1:0] s_rdata;

   logic [PCNT_W-1:0] eff_plen;
   logic              out_free;
   logic [END_W-1:0]  m_ext, j_ext, pos_full;

   hss_ram #(.WIDTH(8), .DEPTH(MAX_PATTERN)) u_pat (
      .clock(clock), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
      .raddr(p_raddr), .rdata(p_rdata)
   );

   hss_ram #(.WIDTH(8), .DEPTH(MAX_LINE)) u_txt (
      .clock(clock), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
      .raddr(t_raddr), .rdata(t_rdata)
   );

   hss_ram #(.WIDTH(PCNT_W), .DEPTH(256)) u_shift (
      .clock(clock), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
      .raddr(s_raddr), .rdata(s_rdata)
   );

   assign eff_plen = pfresh_ff ? '0 : plen_ff;
   assign out_free = ~rvalid_ff | rsp_ready;
   assign m_ext    = END_W'(plen_ff);
   assign j_ext    = END_W'(j_ff);
   assign pos_full = end_ff + 1'b1 - m_ext;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hss_pkg::S_IDLE: begin
            if (item_valid) begin
               if (!item.is_text) begin
                  if (item.last) begin
                     state_in = hss_pkg::S_FILL;
                  end
               end else if (item.last) begin
                  if (pov_ff || tov_in || plen_ff == '0) begin
                     state_in = hss_pkg::S_OUT;
                  end else begin
                     state_in = hss_pkg::S_CHK;
                  end
               end
            end
         end
         hss_pkg::S_FILL: begin
            if (idx_ff == 8'hFF) begin
               state_in = (plen_ff > PCNT_W'(1)) ? hss_pkg::S_WRD : hss_pkg::S_IDLE;
            end
         end
         hss_pkg::S_WRD:  state_in = hss_pkg::S_WWR;
         hss_pkg::S_WWR: begin
            state_in = ((END_W'(k_ff) + END_W'(2)) < m_ext) ? hss_pkg::S_WRD
                                                            : hss_pkg::S_IDLE;
         end
         hss_pkg::S_CHK: begin
            state_in = (end_ff < END_W'(tlen_ff)) ? hss_pkg::S_CRD : hss_pkg::S_OUT;
         end
         hss_pkg::S_CRD:  state_in = hss_pkg::S_CCMP;
         hss_pkg::S_CCMP: begin
            if (t_rdata == p_rdata) begin
               state_in = (j_ff == PCNT_W'(1)) ? hss_pkg::S_OUT : hss_pkg::S_CRD;
            end else begin
               state_in = hss_pkg::S_TRD;
            end
         end
         hss_pkg::S_TRD:  state_in = hss_pkg::S_TBL;
         hss_pkg::S_TBL:  state_in = hss_pkg::S_SHF;
         hss_pkg::S_SHF:  state_in = hss_pkg::S_CHK;
         hss_pkg::S_OUT: begin
            if (out_free) begin
               state_in = hss_pkg::S_IDLE;
            end
         end
         default: state_in = hss_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      plen_in    = plen_ff;
      pfresh_in  = pfresh_ff;
      pov_in     = pov_ff;
      tlen_in    = tlen_ff;
      tov_in     = tov_ff;
      idx_in     = idx_ff;
      k_in       = k_ff;
      j_in       = j_ff;
      end_in     = end_ff;
      status_in  = status_ff;
      pos_in     = pos_ff;
      rvalid_in  = rvalid_ff & ~rsp_ready;
      rstatus_in = rstatus_ff;
      rpos_in    = rpos_ff;
      item_pop   = 1'b0;
      p_we       = 1'b0;
      t_we       = 1'b0;
      s_we       = 1'b0;
      p_waddr    = eff_plen[PA_W-1:0];
      p_wdata    = item.data;
      t_waddr    = tlen_ff[LA_W-1:0];
      t_wdata    = item.data;
      s_waddr    = idx_ff;
      s_wdata    = plen_ff;
      p_raddr    = k_ff[PA_W-1:0];
      t_raddr    = LA_W'(end_ff - (m_ext - j_ext));
      s_raddr    = t_rdata;
      case (state_ff)
         hss_pkg::S_IDLE: begin
            item_pop = item_valid;
            if (item_valid) begin
               if (!item.is_text) begin
                  pfresh_in = item.last;
                  if (eff_plen < PCNT_W'(MAX_PATTERN)) begin
                     p_we    = 1'b1;
                     plen_in = eff_plen + 1'b1;
                     pov_in  = pfresh_ff ? 1'b0 : pov_ff;
                  end else begin
                     plen_in = eff_plen;
                     pov_in  = 1'b1;
                  end
                  idx_in = '0;
                  k_in   = '0;
               end else begin
                  if (tlen_ff < LCNT_W'(MAX_LINE)) begin
                     t_we    = 1'b1;
                     tlen_in = tlen_ff + 1'b1;
                  end else begin
                     tov_in = 1'b1;
                  end
                  end_in = m_ext - 1'b1;
                  pos_in = '0;
                  if (pov_ff) begin
                     status_in = hss_pkg::ST_PAT_LONG;
                  end else if (tov_in) begin
                     status_in = hss_pkg::ST_LINE_LONG;
                  end else if (plen_ff == '0) begin
                     status_in = hss_pkg::ST_MATCH;
                  end else begin
                     status_in = hss_pkg::ST_NO_MATCH;
                  end
               end
            end
         end
         hss_pkg::S_FILL: begin
            s_we   = 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         hss_pkg::S_WWR: begin
            s_we    = 1'b1;
            s_waddr = p_rdata;
            s_wdata = PCNT_W'(m_ext - 1'b1 - END_W'(k_ff));
            k_in    = k_ff + 1'b1;
         end
         hss_pkg::S_CHK: begin
            j_in = plen_ff;
         end
         hss_pkg::S_CRD: begin
            p_raddr = PA_W'(j_ff - 1'b1);
         end
         hss_pkg::S_CCMP: begin
            if (t_rdata == p_rdata) begin
               j_in = j_ff - 1'b1;
               if (j_ff == PCNT_W'(1)) begin
                  status_in = hss_pkg::ST_MATCH;
                  pos_in    = pos_full[hss_pkg::POS_W-1:0];
               end
            end
         end
         hss_pkg::S_TRD: begin
            t_raddr = end_ff[LA_W-1:0];
         end
         hss_pkg::S_SHF: begin
            end_in = end_ff + ((s_rdata == '0) ? END_W'(1) : END_W'(s_rdata));
         end
         hss_pkg::S_OUT: begin
            if (out_free) begin
               rvalid_in  = 1'b1;
               rstatus_in = status_ff;
               rpos_in    = pos_ff;
               tlen_in    = '0;
               tov_in     = 1'b0;
            end
         end
         default: begin
            rvalid_in = rvalid_ff & ~rsp_ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= hss_pkg::S_IDLE;
         plen_ff   <= '0;
         pfresh_ff <= 1'b1;
         pov_ff    <= 1'b0;
         tlen_ff   <= '0;
         tov_ff    <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         plen_ff   <= plen_in;
         pfresh_ff <= pfresh_in;
         pov_ff    <= pov_in;
         tlen_ff   <= tlen_in;
         tov_ff    <= tov_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      k_ff       <= k_in;
      j_ff       <= j_in;
      end_ff     <= end_in;
      status_ff  <= status_in;
      pos_ff     <= pos_in;
      rstatus_ff <= rstatus_in;
      rpos_ff    <= rpos_in;
   end

   assign rsp_valid  = rvalid_ff;
   assign rsp_status = rstatus_ff;
   assign rsp_pos    = rpos_ff;

endmodule

// ----- sv/horspool_substring_search_top.sv -----
// ----------------------------------------------------------------------------
// horspool_substring_search_top
// Horspool substring search over a loaded pattern and a buffered text line.
// ----------------------------------------------------------------------------
// Input transactions carry one byte each: tuser low selects a pattern byte,
// tuser high a text line byte, and tlast marks the final byte of either.
// A pattern ending with tlast builds the shift table: every entry is preset
// first, then one entry is written per pattern byte but the final one.
// A line ending with tlast starts the search and yields one result
// transaction carrying the status and the first match position.
// Each byte is stored as the engine pops it; the search compares one byte
// at a time and reads the line again per window shift, set by the single
// read port of the line memory. A four-entry queue takes input while the
// engine works. A result waits in the output register while the receiver
// stalls; the engine holds with its next result, the queue fills, tready drops.
// After reset the pattern is empty, the line is empty and no result waits.
// ----------------------------------------------------------------------------
module horspool_substring_search_top #(
   parameter int MAX_PATTERN = hss_pkg::MAX_PATTERN_DEFAULT,
   parameter int MAX_LINE    = hss_pkg::MAX_LINE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] op
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [1:0] status, [12:2] match_position
);

   logic                         q_valid;
   logic                         q_pop;
   hss_pkg::item_type            q_item;
   logic [hss_pkg::STATUS_W-1:0] status;
   logic [hss_pkg::POS_W-1:0]    pos;

   hss_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_op(req_tuser), .in_data(req_tdata), .in_last(req_tlast),
      .out_valid(q_valid), .out_pop(q_pop), .out_item(q_item)
   );

   hss_engine #(.MAX_PATTERN(MAX_PATTERN), .MAX_LINE(MAX_LINE)) u_engine (
      .clock(clock), .reset(reset),
      .item_valid(q_valid), .item_pop(q_pop), .item(q_item),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_status(status), .rsp_pos(pos)
   );

   assign rsp_tdata = {3'b000, pos, status};

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Horspool substring search block.
// ----------------------------------------------------------------------------
// Pattern and line bytes are streamed in under random idling of both sides.
// A scoreboard keeps its own pattern, shift table and line, predicts the
// status and position of every search and checks each result in order.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAXP = 64;
   localparam int MAXL = 2048;
   localparam bit OP_PATTERN = 1'b0;
   localparam bit OP_TEXT    = 1'b1;

   class search_scoreboard;
      logic [7:0]  pat [MAXP];
      logic [6:0]  shift_of [256];
      logic [7:0]  line_buf [MAXL];
      int          pat_len = 0;
      int          line_len = 0;
      bit          fresh = 1;
      bit          pat_over = 0;
      bit          line_over = 0;
      logic [12:0] pending [$];
      int          errors = 0;

      function automatic int locate(output int where);
         int fin;
         int j;
         int step;
         where = 0;
         if (pat_len == 0) return 1;
         fin = pat_len - 1;
         while (fin < line_len) begin
            j = pat_len;
            while (j > 0 && line_buf[fin - (pat_len - j)] == pat[j-1]) j--;
            if (j == 0) begin
               where = fin + 1 - pat_len;
               return 1;
            end
            step = shift_of[line_buf[fin]];
            if (step == 0) step = 1;
            fin += step;
         end
         return 0;
      endfunction

      function automatic void note_item(bit op, logic [7:0] b, bit lst);
         hss_pkg::status_type st;
         int pos;
         if (op == OP_PATTERN) begin
            if (fresh) begin
               pat_len = 0;
               pat_over = 0;
               fresh = 0;
            end
            if (pat_len < MAXP) pat[pat_len++] = b;
            else pat_over = 1;
            if (lst) begin
               for (int k = 0; k < 256; k++) shift_of[k] = 7'(pat_len);
               for (int k = 0; k + 1 < pat_len; k++) shift_of[pat[k]] = 7'(pat_len - 1 - k);
               fresh = 1;
            end
            return;
         end
         if (line_len < MAXL) line_buf[line_len++] = b;
         else line_over = 1;
         if (!lst) return;
         pos = 0;
         if (pat_over) st = hss_pkg::ST_PAT_LONG;
         else if (line_over) st = hss_pkg::ST_LINE_LONG;
         else if (locate(pos)) st = hss_pkg::ST_MATCH;
         else begin
            st = hss_pkg::ST_NO_MATCH;
            pos = 0;
         end
         pending.push_back({11'(pos), st});
         line_len = 0;
         line_over = 0;
      endfunction

      function automatic void check_result(logic [15:0] got);
         logic [12:0] want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result transaction %h", got);
            return;
         end
         want = pending.pop_front();
         if (got[1:0] !== want[1:0] || got[12:2] !== want[12:2] || got[15:13] !== 3'b0) begin
            errors++;
            if (errors <= 10)
               $display("result mismatch: status %0d/%0d position %0d/%0d (exp/act)",
                        want[1:0], got[1:0], want[12:2], got[12:2]);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = 0;
   logic        req_tuser = 0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;

   search_scoreboard sb = new();
   int send_idle = 0;
   int recv_stall = 0;
   int cycles = 0;

   horspool_substring_search_top DUT (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall);
   end

   task automatic push_byte(bit op, logic [7:0] b, bit lst);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= b;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      sb.note_item(op, b, lst);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic send_pattern(int len, int alpha);
      for (int i = 0; i < len; i++)
         push_byte(OP_PATTERN, 8'($urandom_range(alpha - 1)), i == len - 1);
   endtask

   task automatic send_line(int len, int alpha, bit plant);
      logic [7:0] txt [];
      int at;
      txt = new[len];
      for (int i = 0; i < len; i++) txt[i] = 8'($urandom_range(alpha - 1));
      if (plant && sb.pat_len > 0 && sb.pat_len <= len && !sb.pat_over) begin
         at = $urandom_range(len - sb.pat_len);
         for (int i = 0; i < sb.pat_len; i++) txt[at + i] = sb.pat[i];
      end
      for (int i = 0; i < len; i++) push_byte(OP_TEXT, txt[i], i == len - 1);
   endtask

   initial begin
      int alpha;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: empty pattern, byte extremes, pattern overflow, partial load.
      push_byte(OP_TEXT, 8'h00, 1'b1);
      push_byte(OP_TEXT, 8'hff, 1'b0);
      push_byte(OP_TEXT, 8'h00, 1'b1);
      push_byte(OP_PATTERN, 8'hff, 1'b0);
      push_byte(OP_PATTERN, 8'h00, 1'b1);
      push_byte(OP_TEXT, 8'h55, 1'b0);
      push_byte(OP_TEXT, 8'hff, 1'b0);
      push_byte(OP_TEXT, 8'h00, 1'b1);
      push_byte(OP_TEXT, 8'h00, 1'b1);
      push_byte(OP_PATTERN, 8'haa, 1'b1);
      push_byte(OP_TEXT, 8'haa, 1'b1);
      push_byte(OP_PATTERN, 8'h01, 1'b0);
      push_byte(OP_TEXT, 8'h01, 1'b1);
      push_byte(OP_PATTERN, 8'h02, 1'b1);
      drain();
      for (int i = 0; i < 70; i++) push_byte(OP_PATTERN, 8'(i), i == 69);
      push_byte(OP_TEXT, 8'h00, 1'b1);
      drain();
      send_pattern(MAXP, 4);
      send_line(MAXP, 4, 1'b1);
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         send_idle  = (ph == 1 || ph == 3) ? (ph == 1 ? 48 : 22) : 0;
         recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 48 : 22) : 0;
         for (int r = 0; r < 8; r++) begin
            alpha = ($urandom_range(3) == 0) ? 256 : $urandom_range(2, 4);
            if ($urandom_range(9) == 0) send_pattern($urandom_range(1, MAXP), alpha);
            else send_pattern($urandom_range(1, 6), alpha);
            for (int l = 0; l < 3; l++) begin
               if ($urandom_range(7) == 0) begin
                  push_byte(OP_PATTERN, 8'($urandom), 1'b0);
                  push_byte(OP_TEXT, 8'($urandom), 1'b1);
                  push_byte(OP_PATTERN, 8'($urandom), 1'b1);
               end
               send_line($urandom_range(1, 12), alpha, 1'($urandom_range(1)));
            end
         end
         drain();
      end
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

// ----- files.f -----
sv/hss_pkg.sv
sv/hss_ram.sv
sv/hss_front.sv
sv/hss_engine.sv
sv/horspool_substring_search_top.sv
tb/tb.sv
